/* hdl/srt_pkg.sv */
// Package for the snapshot revision tracker: constants, relation codes,
// controller state type and the controller/datapath command and status structs.
// No dependencies.
package srt_pkg;

  localparam int RETIRED_DEPTH_DEF = 16;
  localparam int ID_W = 32;
  localparam int DIST_W = 32;
  localparam int REL_W = 3;

  localparam logic CMD_ACCEPT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [REL_W-1:0] {
    REL_EXACT = 3'd0,
    REL_NEWER = 3'd1,
    REL_OLDER = 3'd2,
    REL_DIFFERENT = 3'd3,
    REL_RETIRED = 3'd4,
    REL_POLICY = 3'd5,
    REL_MALFORMED = 3'd6
  } rel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic load_in;    // capture item, clear scan index and hit flags
    logic scan_issue; // read the next retired entry
    logic commit;     // apply decision, load result register
  } ctl_t;

  typedef struct packed {
    logic scan_done;  // every entry below the fill count has been read
  } sts_t;

endpackage

/* hdl/srt_datapath.sv */
// Datapath of the snapshot revision tracker: item capture, current identity,
// retired-ID memory with its scan compare, decision logic and result register.
// Depends on srt_pkg.
module srt_datapath
  import srt_pkg::*;
#(
  parameter int RETIRED_DEPTH = RETIRED_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_t                     ctl,
  output sts_t                     sts,
  input  logic                     cmd,
  input  logic                     grid_ok,
  input  logic [ID_W-1:0]          producer_id,
  input  logic [ID_W-1:0]          rev_number,
  input  logic [ID_W-1:0]          fingerprint,
  input  logic signed [DIST_W-1:0] critical_mm,
  input  logic signed [DIST_W-1:0] preferred_mm,
  output logic                     accepted,
  output logic [REL_W-1:0]         relation_code,
  output logic                     retire_overflow,
  output logic                     have_current
);

  localparam int AW = (RETIRED_DEPTH > 1) ? $clog2(RETIRED_DEPTH) : 1;
  localparam int CW = $clog2(RETIRED_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(RETIRED_DEPTH);

  // captured item
  logic                     in_cmd;
  logic                     in_grid;
  logic [ID_W-1:0]          in_prod;
  logic [ID_W-1:0]          in_rev;
  logic [ID_W-1:0]          in_fp;
  logic signed [DIST_W-1:0] in_crit;
  logic signed [DIST_W-1:0] in_pref;

  // current snapshot identity
  logic            cur_valid;
  logic [ID_W-1:0] cur_prod;
  logic [ID_W-1:0] cur_rev;
  logic [ID_W-1:0] cur_fp;

  logic [ID_W-1:0] retired_mem [RETIRED_DEPTH];
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [ID_W-1:0] rdata;
  logic            cmp_en;
  logic            hit_prod;
  logic            hit_cur;

  logic            ok;
  logic            do_retire;
  logic            room;
  logic [REL_W-1:0] rel;

  assign sts.scan_done = (idx == count);
  assign room = (count < DEPTH_C);

  always_comb begin
    ok = in_grid && (in_prod != '0) && (in_rev != '0) && (in_fp != '0) &&
         !in_crit[DIST_W-1] && (in_pref >= in_crit) && !hit_prod &&
         !(cur_valid && (in_prod == cur_prod) && (in_rev <= cur_rev));
    do_retire = ok && cur_valid && (in_prod != cur_prod) && !hit_cur;
  end

  always_comb begin
    priority if (!cur_valid || in_prod == '0 || in_rev == '0 || in_fp == '0) begin
      rel = REL_MALFORMED;
    end else if (in_prod != cur_prod) begin
      rel = hit_prod ? REL_RETIRED : REL_DIFFERENT;
    end else if (in_fp != cur_fp) begin
      rel = REL_POLICY;
    end else if (in_rev == cur_rev) begin
      rel = REL_EXACT;
    end else if (cur_rev > in_rev) begin
      rel = REL_NEWER;
    end else begin
      rel = REL_OLDER;
    end
  end

  // retired-ID memory: one write port at commit, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (ctl.commit && in_cmd == CMD_ACCEPT && do_retire && room) begin
      retired_mem[count[AW-1:0]] <= cur_prod;
    end
    if (ctl.scan_issue) begin
      rdata <= retired_mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      in_cmd  <= cmd;
      in_grid <= grid_ok;
      in_prod <= producer_id;
      in_rev  <= rev_number;
      in_fp   <= fingerprint;
      in_crit <= critical_mm;
      in_pref <= preferred_mm;
    end
    if (ctl.commit) begin
      accepted        <= (in_cmd == CMD_ACCEPT) && ok;
      relation_code   <= (in_cmd == CMD_ACCEPT) ? REL_EXACT : rel;
      retire_overflow <= (in_cmd == CMD_ACCEPT) && do_retire && !room;
      have_current    <= cur_valid || ((in_cmd == CMD_ACCEPT) && ok);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_prod  <= '0;
      cur_rev   <= '0;
      cur_fp    <= '0;
      count     <= '0;
      idx       <= '0;
      cmp_en    <= 1'b0;
      hit_prod  <= 1'b0;
      hit_cur   <= 1'b0;
    end else begin
      cmp_en <= ctl.scan_issue;
      if (ctl.load_in) begin
        idx      <= '0;
        hit_prod <= 1'b0;
        hit_cur  <= 1'b0;
      end else begin
        if (ctl.scan_issue) begin
          idx <= idx + CW'(1);
        end
        // the compare uses the registered read data, in the cycle after the read was issued
        if (cmp_en) begin
          hit_prod <= hit_prod || (rdata == in_prod);
          hit_cur  <= hit_cur || (rdata == cur_prod);
        end
      end
      if (ctl.commit && in_cmd == CMD_ACCEPT && ok) begin
        cur_valid <= 1'b1;
        cur_prod  <= in_prod;
        cur_rev   <= in_rev;
        cur_fp    <= in_fp;
        if (do_retire && room) begin
          count <= count + CW'(1);
        end
      end
    end
  end

endmodule

/* hdl/srt_ctrl.sv */
// Controller of the snapshot revision tracker: sequences capture, memory scan
// and commit, and owns the input ready and result valid handshake flags.
// Depends on srt_pkg.
module srt_ctrl
  import srt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCAN;
      S_SCAN:   if (sts.scan_done) state_next = S_DECIDE;
      S_DECIDE: if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    ctl.load_in    = 1'b0;
    ctl.scan_issue = 1'b0;
    ctl.commit     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        ctl.load_in = in_valid;
      end
      S_SCAN:   ctl.scan_issue = !sts.scan_done;
      S_DECIDE: ctl.commit = slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/snapshot_revision_tracker_unit.sv */
// Top level of the snapshot revision tracker: controller plus datapath.
// Depends on srt_pkg, srt_ctrl, srt_datapath.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   cmd grid_ok producer_id rev_number fingerprint
//                                  critical_mm preferred_mm
//   out      out_valid / out_ready accepted relation_code retire_overflow have_current
//
// An item passes through capture, then one read per retired entry through the
// single memory read port plus a step to finish the scan, and then a decide
// step that loads the result register.
// Synchronous reset clears the current identity and the fill count; the memory
// itself is never cleared, only entries below the fill count are read.
// A new item is taken while the previous result waits; a stalled output holds
// the block in its decide step.
module snapshot_revision_tracker_unit
  import srt_pkg::*;
#(
  parameter int RETIRED_DEPTH = RETIRED_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     cmd,
  input  logic                     grid_ok,
  input  logic [ID_W-1:0]          producer_id,
  input  logic [ID_W-1:0]          rev_number,
  input  logic [ID_W-1:0]          fingerprint,
  input  logic signed [DIST_W-1:0] critical_mm,
  input  logic signed [DIST_W-1:0] preferred_mm,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     accepted,
  output logic [REL_W-1:0]         relation_code,
  output logic                     retire_overflow,
  output logic                     have_current
);

  ctl_t ctl;
  sts_t sts;

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  srt_datapath #(
    .RETIRED_DEPTH (RETIRED_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .cmd             (cmd),
    .grid_ok         (grid_ok),
    .producer_id     (producer_id),
    .rev_number      (rev_number),
    .fingerprint     (fingerprint),
    .critical_mm     (critical_mm),
    .preferred_mm    (preferred_mm),
    .accepted        (accepted),
    .relation_code   (relation_code),
    .retire_overflow (retire_overflow),
    .have_current    (have_current)
  );

endmodule

/* tb/srt_identity_checker.sv */
`timescale 1ns / 100ps
// Result checker for the snapshot revision tracker: watches both item channels,
// tracks the current identity and retired producer list, compares every result.
// Depends on srt_pkg.
module srt_identity_checker
  import srt_pkg::*;
#(
  parameter int RETIRED_DEPTH = RETIRED_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     cmd,
  input  logic                     grid_ok,
  input  logic [ID_W-1:0]          producer_id,
  input  logic [ID_W-1:0]          rev_number,
  input  logic [ID_W-1:0]          fingerprint,
  input  logic signed [DIST_W-1:0] critical_mm,
  input  logic signed [DIST_W-1:0] preferred_mm,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     accepted,
  input  logic [REL_W-1:0]         relation_code,
  input  logic                     retire_overflow,
  input  logic                     have_current,
  output int                       mismatch_count,
  output int                       outstanding
);

  typedef struct packed {
    logic accepted;
    rel_t relation;
    logic overflow;
    logic have_current;
  } tracker_result_t;

  tracker_result_t expected_results[$];

  logic            cur_valid;
  logic [ID_W-1:0] cur_producer;
  logic [ID_W-1:0] cur_revision;
  logic [ID_W-1:0] cur_policy;
  logic [ID_W-1:0] retired_ids[RETIRED_DEPTH];
  int              retired_fill;

  int failures = 0;
  int pending_q = 0;

  assign mismatch_count = failures;
  assign outstanding = pending_q;

  function automatic logic producer_retired(logic [ID_W-1:0] id);
    for (int i = 0; i < retired_fill; i++)
      if (retired_ids[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  // updates the shadow identity and returns the result the item should produce
  function automatic tracker_result_t track_item(
    logic c, logic g, logic [ID_W-1:0] p, logic [ID_W-1:0] r, logic [ID_W-1:0] f,
    logic signed [DIST_W-1:0] crit, logic signed [DIST_W-1:0] pref);
    tracker_result_t res;
    logic            ok;
    res = '{accepted: 1'b0, relation: REL_EXACT, overflow: 1'b0, have_current: 1'b0};
    if (c == CMD_ACCEPT) begin
      ok = g && p != 0 && r != 0 && f != 0 && crit >= 0 && pref >= crit;
      if (ok && producer_retired(p)) ok = 1'b0;
      if (ok && cur_valid && p == cur_producer && r <= cur_revision) ok = 1'b0;
      if (ok) begin
        // producer change retires the old one; a full list drops it
        if (cur_valid && p != cur_producer && !producer_retired(cur_producer)) begin
          if (retired_fill < RETIRED_DEPTH) begin
            retired_ids[retired_fill] = cur_producer;
            retired_fill++;
          end else begin
            res.overflow = 1'b1;
          end
        end
        cur_producer = p;
        cur_revision = r;
        cur_policy = f;
        cur_valid = 1'b1;
        res.accepted = 1'b1;
      end
    end else begin
      if (!cur_valid || p == 0 || r == 0 || f == 0) res.relation = REL_MALFORMED;
      else if (p != cur_producer) res.relation = producer_retired(p) ? REL_RETIRED : REL_DIFFERENT;
      else if (f != cur_policy) res.relation = REL_POLICY;
      else if (r == cur_revision) res.relation = REL_EXACT;
      else res.relation = (cur_revision > r) ? REL_NEWER : REL_OLDER;
    end
    res.have_current = cur_valid;
    return res;
  endfunction

  always @(posedge clk) begin
    tracker_result_t want;
    tracker_result_t got;
    if (rst) begin
      cur_valid = 1'b0;
      cur_producer = '0;
      cur_revision = '0;
      cur_policy = '0;
      retired_fill = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {accepted, rel_t'(relation_code), retire_overflow, have_current};
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with nothing pending: acc=%0b rel=%0d ovf=%0b have=%0b",
                     $realtime, got.accepted, got.relation, got.overflow, got.have_current);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10) begin
              $write("%0t: mismatch: expected acc=%0b rel=%0d ovf=%0b have=%0b,",
                     $realtime, want.accepted, want.relation, want.overflow,
                     want.have_current);
              $display(" got acc=%0b rel=%0d ovf=%0b have=%0b",
                       got.accepted, got.relation, got.overflow, got.have_current);
            end
          end
        end
      end
      if (in_valid && in_ready)
        expected_results = {expected_results,
                            track_item(cmd, grid_ok, producer_id, rev_number,
                                       fingerprint, critical_mm, preferred_mm)};
    end
    pending_q <= expected_results.size();
  end

endmodule

/* tb/snapshot_revision_tracker_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench top for snapshot_revision_tracker_unit: clock, reset, directed and
// random item stimulus over idle/stall phases, and the verdict.
// Depends on srt_pkg, snapshot_revision_tracker_unit, srt_identity_checker.
module snapshot_revision_tracker_unit_tb
  import srt_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 220;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     cmd;
  logic                     grid_ok;
  logic [ID_W-1:0]          producer_id;
  logic [ID_W-1:0]          rev_number;
  logic [ID_W-1:0]          fingerprint;
  logic signed [DIST_W-1:0] critical_mm;
  logic signed [DIST_W-1:0] preferred_mm;
  logic                     out_valid;
  logic                     out_ready;
  logic                     accepted;
  logic [REL_W-1:0]         relation_code;
  logic                     retire_overflow;
  logic                     have_current;

  int   mismatches;
  int   outstanding;
  int   cycles = 0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  logic hold_req = 1'b0;

  // what the sender believes the block currently holds
  logic [ID_W-1:0] seen_prod;
  logic [ID_W-1:0] seen_rev;
  logic [ID_W-1:0] seen_fp;
  logic [ID_W-1:0] old_producers[$];

  snapshot_revision_tracker_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .grid_ok(grid_ok), .producer_id(producer_id), .rev_number(rev_number),
    .fingerprint(fingerprint), .critical_mm(critical_mm), .preferred_mm(preferred_mm),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .relation_code(relation_code),
    .retire_overflow(retire_overflow), .have_current(have_current)
  );

  srt_identity_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .grid_ok(grid_ok), .producer_id(producer_id), .rev_number(rev_number),
    .fingerprint(fingerprint), .critical_mm(critical_mm), .preferred_mm(preferred_mm),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .relation_code(relation_code),
    .retire_overflow(retire_overflow), .have_current(have_current),
    .mismatch_count(mismatches), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL snapshot_revision_tracker_unit");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_item(logic c, logic g, logic [ID_W-1:0] p, logic [ID_W-1:0] r,
                           logic [ID_W-1:0] f, logic signed [DIST_W-1:0] crit,
                           logic signed [DIST_W-1:0] pref);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    grid_ok <= g;
    producer_id <= p;
    rev_number <= r;
    fingerprint <= f;
    critical_mm <= crit;
    preferred_mm <= pref;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_old_producer();
    if (old_producers.size() == 0) return $urandom_range(1, 32'hFFFF_FFFF);
    return old_producers[$urandom_range(0, old_producers.size() - 1)];
  endfunction

  // well-formed accepts that walk revisions and change producers,
  // queries around the current identity, some broken accepts and raw noise
  task automatic send_random_item();
    int                       pick;
    int                       kind;
    logic                     c;
    logic                     g;
    logic [ID_W-1:0]          p;
    logic [ID_W-1:0]          r;
    logic [ID_W-1:0]          f;
    logic signed [DIST_W-1:0] crit;
    logic signed [DIST_W-1:0] pref;
    pick = $urandom_range(99);
    c = CMD_ACCEPT;
    g = 1'b1;
    p = seen_prod;
    r = seen_rev + $urandom_range(1, 40);
    f = seen_fp;
    crit = $urandom_range(0, 1) ? $urandom_range(0, 5000) : $urandom_range(0, 32'h7FFF_FFFF);
    pref = crit + $urandom_range(0, 32'h7FFF_FFFF - crit);
    if (pick < 10) begin
      c = 1'($urandom_range(0, 1));
      g = 1'($urandom_range(0, 1));
      p = $urandom;
      r = $urandom;
      f = $urandom;
      crit = $urandom;
      pref = $urandom;
    end else if (pick < 20) begin
      kind = $urandom_range(0, 7);
      case (kind)
        0: g = 1'b0;
        1: p = '0;
        2: r = '0;
        3: f = '0;
        4: crit = {1'b1, 31'($urandom)};
        5: begin
          crit = $urandom_range(1, 32'h7FFF_FFFF);
          pref = crit - $signed($urandom_range(1, 32'h7FFF_FFFF));
        end
        6: r = seen_rev - $urandom_range(0, 3);
        default: p = pick_old_producer();
      endcase
    end else if (pick < 32) begin
      p = $urandom_range(1, 32'hFFFF_FFFF);
      r = $urandom_range(1, 32'hFFFF_0000);
      f = $urandom_range(1, 32'hFFFF_FFFF);
      old_producers = {old_producers, seen_prod};
      seen_prod = p;
      seen_rev = r;
      seen_fp = f;
    end else if (pick < 35) begin
      // back to an earlier producer: retired ones are refused, dropped ones are not
      p = pick_old_producer();
      r = $urandom_range(1, 32'hFFFF_FFFF);
    end else if (pick < 60) begin
      if ($urandom_range(0, 3) == 0) f = $urandom_range(1, 32'hFFFF_FFFF);
      if (r > seen_rev) begin
        seen_rev = r;
        seen_fp = f;
      end
    end else begin
      c = CMD_QUERY;
      g = 1'($urandom_range(0, 1));
      crit = $urandom;
      pref = $urandom;
      r = seen_rev;
      kind = $urandom_range(0, 7);
      case (kind)
        0: ;
        1: r = seen_rev + $urandom_range(1, 1000);
        2: r = seen_rev - $urandom_range(1, 1000);
        3: f = seen_fp ^ $urandom_range(1, 32'hFFFF_FFFF);
        4: p = pick_old_producer();
        5: p = $urandom;
        6: begin
          case ($urandom_range(0, 2))
            0: p = '0;
            1: r = '0;
            default: f = '0;
          endcase
        end
        default: r = $urandom;
      endcase
    end
    send_item(c, g, p, r, f, crit, pref);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_ACCEPT;
    grid_ok <= 1'b0;
    producer_id <= '0;
    rev_number <= '0;
    fingerprint <= '0;
    critical_mm <= '0;
    preferred_mm <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty tracker, every validity rule, every relation, retirement
    send_item(CMD_QUERY, 1'b1, 1, 1, 1, 0, 0);
    send_item(CMD_ACCEPT, 1'b0, 5, 5, 5, 0, 0);
    send_item(CMD_ACCEPT, 1'b1, 0, 5, 5, 0, 0);
    send_item(CMD_ACCEPT, 1'b1, 5, 0, 5, 0, 0);
    send_item(CMD_ACCEPT, 1'b1, 5, 5, 0, 0, 0);
    send_item(CMD_ACCEPT, 1'b1, 5, 5, 5, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(CMD_ACCEPT, 1'b1, 5, 5, 5, 5, 4);
    send_item(CMD_ACCEPT, 1'b1, 32'hFFFF_FFFF, 100, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_ACCEPT, 1'b1, 32'hFFFF_FFFF, 100, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_ACCEPT, 1'b1, 32'hFFFF_FFFF, 99, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_QUERY, 1'b0, 32'hFFFF_FFFF, 100, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_QUERY, 1'b0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_QUERY, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_QUERY, 1'b0, 32'hFFFF_FFFF, 100, 1, 0, 0);
    send_item(CMD_QUERY, 1'b0, 2, 100, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_QUERY, 1'b0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_ACCEPT, 1'b1, 1, 1, 1, 0, 32'sh7FFF_FFFF);
    send_item(CMD_QUERY, 1'b1, 32'hFFFF_FFFF, 100, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_ACCEPT, 1'b1, 32'hFFFF_FFFF, 200, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_ACCEPT, 1'b1, 1, 32'hFFFF_FFFF, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(CMD_QUERY, 1'b0, 1, 32'hFFFF_FFFF, 1, -1, 32'sh8000_0000);
    send_item(CMD_ACCEPT, 1'b1, 1, 32'hFFFF_FFFF, 1, -1, 0);
    seen_prod = 1;
    seen_rev = 32'hFFFF_FFFF;
    seen_fp = 1;
    old_producers = {old_producers, 32'hFFFF_FFFF};
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
          hold_req = 1'b1;  // long output hold-off while items keep coming
        end
        1: begin
          src_idle_pct = 65;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct = 65;
        end
        3: begin
          src_idle_pct = 28;
          snk_stall_pct = 28;
        end
        default: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_random_item();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS snapshot_revision_tracker_unit");
    end else begin
      $display("FAIL snapshot_revision_tracker_unit");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/srt_pkg.sv
hdl/srt_datapath.sv
hdl/srt_ctrl.sv
hdl/snapshot_revision_tracker_unit.sv
tb/srt_identity_checker.sv
tb/snapshot_revision_tracker_unit_tb.sv
